FILE: hdl/ctl_pkg.sv
// Shared constants and helpers for the closed tour length block.
package ctl_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF  = 8;
	localparam int MAX_POINTS_DEF = 16384;

	// number of root bits one edge produces: integer pairs plus fraction bits
	function automatic int ctl_steps(input int coord_bits, input int frac_bits);
		return coord_bits + 1 + frac_bits;
	endfunction

endpackage

FILE: hdl/ctl_sqrt.sv
// Restoring square root unit, one root bit per cycle.
module ctl_sqrt #(
	parameter int COORD_BITS = ctl_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = ctl_pkg::FRAC_BITS_DEF
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         start,
	input  logic [2*(COORD_BITS+1)-1:0]                  radicand,
	output logic                                         done,
	output logic [ctl_pkg::ctl_steps(COORD_BITS, FRAC_BITS)-1:0] root
);
	import ctl_pkg::*;

	localparam int STEPS    = ctl_steps(COORD_BITS, FRAC_BITS);
	localparam int RAD_BITS = 2 * (COORD_BITS + 1);
	localparam int REM_BITS = STEPS + 2;
	localparam int CNT_BITS = $clog2(STEPS + 1);

	logic [RAD_BITS-1:0] rad_q;
	logic [REM_BITS-1:0] rem_q;
	logic [STEPS-1:0]    root_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                busy_q;
	logic                done_q;

	logic [REM_BITS+1:0] rem_sh;
	logic [REM_BITS+1:0] trial;
	logic                take;
	logic [REM_BITS+1:0] rem_nx;

	always_comb begin
		rem_sh = {rem_q, rad_q[RAD_BITS-1 -: 2]};
		trial  = {2'b00, root_q, 2'b01};
		take   = (rem_sh >= trial);
		rem_nx = take ? (rem_sh - trial) : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			// fraction steps shift in zero pairs below the radicand
			rad_q  <= {rad_q[RAD_BITS-3:0], 2'b00};
			rem_q  <= rem_nx[REM_BITS-1:0];
			root_q <= {root_q[STEPS-2:0], take};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

FILE: hdl/closed_tour_length.sv
// Closed Euclidean tour length: a request per point, total on the last point.
// First point: stored as first and previous point. Other points: an edge (ST_SQX, ST_SQY
// square the x and y distances, ST_ROOT waits for the root bits of the shared sqrt unit,
// ST_ADD adds the root to the sum), then a return to ST_IDLE for the next request. Last point:
// its edge, the closing edge and ST_FIN, which loads the result once its register is free.
// One point at a time; reset clears control state and the running sum, no clearing pass.
module closed_tour_length #(
	parameter int COORD_BITS = ctl_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = ctl_pkg::FRAC_BITS_DEF,
	parameter int MAX_POINTS = ctl_pkg::MAX_POINTS_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          s_axis_tvalid,
	output logic                                          s_axis_tready,
	// point_x, point_y
	input  logic [((2*COORD_BITS+7)/8)*8-1:0]             s_axis_tdata,
	// last_point
	input  logic                                          s_axis_tlast,
	output logic                                          m_axis_tvalid,
	input  logic                                          m_axis_tready,
	// tour_length
	output logic [((COORD_BITS+FRAC_BITS+$clog2(MAX_POINTS)+8)/8)*8-1:0] m_axis_tdata,
	// length_saturated
	output logic                                          m_axis_tuser
);
	import ctl_pkg::*;

	localparam int STEPS     = ctl_steps(COORD_BITS, FRAC_BITS);
	localparam int MAG_BITS  = COORD_BITS + 1;
	localparam int D2_BITS   = 2 * MAG_BITS;
	localparam int SUM_BITS  = COORD_BITS + 1 + FRAC_BITS + $clog2(MAX_POINTS);
	localparam int OUT_BITS  = ((SUM_BITS + 7) / 8) * 8;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SQX  = 3'd1;
	localparam logic [2:0] ST_SQY  = 3'd2;
	localparam logic [2:0] ST_ROOT = 3'd3;
	localparam logic [2:0] ST_ADD  = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;

	logic [2:0] state_q;

	logic signed [COORD_BITS-1:0] first_x_q, first_y_q;
	logic signed [COORD_BITS-1:0] prev_x_q, prev_y_q;
	logic signed [COORD_BITS-1:0] cur_x_q, cur_y_q;
	logic                         last_q;
	logic                         closing_q;
	logic                         started_q;
	logic [SUM_BITS-1:0]          sum_q;
	logic                         sat_q;
	logic [D2_BITS-1:0]           d2_q;
	logic                         out_valid_q;
	logic [SUM_BITS-1:0]          out_len_q;
	logic                         out_sat_q;

	logic                         in_fire;
	logic signed [COORD_BITS-1:0] in_x, in_y;
	logic signed [COORD_BITS-1:0] a_x, a_y, b_x, b_y;
	logic signed [MAG_BITS-1:0]   dx, dy;
	logic [MAG_BITS-1:0]          mag_x, mag_y, mul_in;
	logic [D2_BITS-1:0]           sq;
	logic                         root_start;
	logic                         root_done;
	logic [STEPS-1:0]             root;
	logic [SUM_BITS:0]            sum_ext;
	logic                         out_free;

	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign in_x    = s_axis_tdata[COORD_BITS-1:0];
	assign in_y    = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];

	// closing edge runs from the last point back to the first
	always_comb begin
		a_x    = closing_q ? cur_x_q : prev_x_q;
		a_y    = closing_q ? cur_y_q : prev_y_q;
		b_x    = closing_q ? first_x_q : cur_x_q;
		b_y    = closing_q ? first_y_q : cur_y_q;
		dx     = {b_x[COORD_BITS-1], b_x} - {a_x[COORD_BITS-1], a_x};
		dy     = {b_y[COORD_BITS-1], b_y} - {a_y[COORD_BITS-1], a_y};
		mag_x  = dx[MAG_BITS-1] ? MAG_BITS'(-dx) : MAG_BITS'(dx);
		mag_y  = dy[MAG_BITS-1] ? MAG_BITS'(-dy) : MAG_BITS'(dy);
		mul_in = (state_q == ST_SQX) ? mag_x : mag_y;
		sq     = mul_in * mul_in;
		sum_ext = {1'b0, sum_q} + {{(SUM_BITS + 1 - STEPS){1'b0}}, root};
	end

	assign root_start = (state_q == ST_SQY);
	assign out_free   = !out_valid_q || m_axis_tready;

	ctl_sqrt #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (root_start),
		.radicand(d2_q + sq),
		.done    (root_done),
		.root    (root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			started_q   <= 1'b0;
			closing_q   <= 1'b0;
			last_q      <= 1'b0;
			sum_q       <= '0;
			sat_q       <= 1'b0;
			first_x_q   <= '0;
			first_y_q   <= '0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						last_q    <= s_axis_tlast;
						// a one-point tour goes straight to its closing edge
						closing_q <= !started_q && s_axis_tlast;
						if (!started_q) begin
							first_x_q <= in_x;
							first_y_q <= in_y;
							prev_x_q  <= in_x;
							prev_y_q  <= in_y;
							sum_q     <= '0;
							sat_q     <= 1'b0;
							started_q <= 1'b1;
							if (s_axis_tlast) begin
								state_q <= ST_SQX;
							end
						end else begin
							state_q <= ST_SQX;
						end
					end
				end
				ST_SQX: begin
					state_q <= ST_SQY;
				end
				ST_SQY: begin
					state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					if (root_done) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					if (sum_ext[SUM_BITS]) begin
						sum_q <= '1;
						sat_q <= 1'b1;
					end else begin
						sum_q <= sum_ext[SUM_BITS-1:0];
					end
					if (closing_q) begin
						state_q <= ST_FIN;
					end else begin
						prev_x_q <= cur_x_q;
						prev_y_q <= cur_y_q;
						if (last_q) begin
							closing_q <= 1'b1;
							state_q   <= ST_SQX;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_FIN: begin
					// hold until the result register is free
					if (out_free) begin
						started_q   <= 1'b0;
						closing_q   <= 1'b0;
						sum_q       <= '0;
						sat_q       <= 1'b0;
						first_x_q   <= '0;
						first_y_q   <= '0;
						prev_x_q    <= '0;
						prev_y_q    <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cur_x_q <= in_x;
			cur_y_q <= in_y;
		end
		if (state_q == ST_SQX) begin
			d2_q <= sq;
		end
		if (state_q == ST_FIN && out_free) begin
			out_len_q <= sum_q;
			out_sat_q <= sat_q;
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_BITS'(out_len_q);
	assign m_axis_tuser  = out_sat_q;

	a_root_in_root_state: assert property (@(posedge clk) disable iff (!arst_n)
		root_done |-> (state_q == ST_ROOT))
		else $error("root result outside the root wait");

	a_busy_after_edge_request: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && started_q) |=> !s_axis_tready)
		else $error("request taken while an edge is still pending");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> ($past(state_q) == ST_FIN))
		else $error("result raised outside the finish step");

endmodule
